[rtl/core/i2cme_pkg.sv]
// i2cme_pkg: payload types, command and status codes and the bus sequence table
// for the i2c master byte engine. No dependencies.
`timescale 1ns / 1ps

package i2cme_pkg;

   // command codes of the mode field
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NACK    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
   localparam logic [1:0] STATUS_REFUSED = 2'd3;

   // register indexes (byte address 4 * index)
   localparam logic [1:0] REG_ENABLED     = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
   localparam logic [1:0] REG_TIMEOUT     = 2'd2;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd10000;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       scl_in;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_byte;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_SDA_HI,
      ACT_SDA_LO,
      ACT_SCL_HI,
      ACT_SCL_LO,
      ACT_WAIT,
      ACT_SDA_BIT,
      ACT_ACK_SAMPLE,
      ACT_BIT_SAMPLE,
      ACT_LOOP,
      ACT_SDA_ACK
   } act_type;

   typedef struct packed {
      act_type    act;
      logic       dly;
      logic       last;
      logic [4:0] jump;
   } seq_entry_type;

   localparam int NUM_PHASES = 30;

   localparam logic [4:0] PH_IDLE  = 5'd0;
   localparam logic [4:0] PH_START = 5'd1;
   localparam logic [4:0] PH_STOP  = 5'd6;
   localparam logic [4:0] PH_WRITE = 5'd10;
   localparam logic [4:0] PH_READ  = 5'd19;

   localparam seq_entry_type SEQ_TABLE [NUM_PHASES] = '{
      '{ACT_NOP,        1'b0, 1'b1, 5'd0},
      // start
      '{ACT_SDA_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_SDA_LO,     1'b1, 1'b0, 5'd0},
      '{ACT_SCL_LO,     1'b1, 1'b1, 5'd0},
      // stop
      '{ACT_SDA_LO,     1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_SDA_HI,     1'b1, 1'b1, 5'd0},
      // write byte
      '{ACT_SDA_BIT,    1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_SCL_LO,     1'b1, 1'b0, 5'd0},
      '{ACT_LOOP,       1'b0, 1'b0, PH_WRITE},
      '{ACT_SDA_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_ACK_SAMPLE, 1'b1, 1'b1, 5'd0},
      // read byte
      '{ACT_SDA_HI,     1'b0, 1'b0, 5'd0},
      '{ACT_NOP,        1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_BIT_SAMPLE, 1'b0, 1'b0, 5'd0},
      '{ACT_LOOP,       1'b0, 1'b0, PH_READ + 5'd1},
      '{ACT_SDA_ACK,    1'b1, 1'b0, 5'd0},
      '{ACT_SCL_HI,     1'b1, 1'b0, 5'd0},
      '{ACT_WAIT,       1'b0, 1'b0, 5'd0},
      '{ACT_SCL_LO,     1'b1, 1'b0, 5'd0},
      '{ACT_SDA_HI,     1'b0, 1'b1, 5'd0}
   };

endpackage

[rtl/core/i2c_master_byte_engine.sv]
// i2c_master_byte_engine: open-drain i2c master, one bus tick per req transfer,
// one status word per rsp transfer. Depends on i2cme_pkg.
//
//   port group  | direction | transfer
//   req_*       | in        | one bus tick: command, tx byte, ack choice, sampled scl/sda
//   rsp_*       | out       | line drives, busy, done strobe, status, rx byte
//   psel/p*     | in/out    | register write/read, setup then access cycle
//
// a tick walks up to 5 sequence entries per cycle in the unrolled step logic between the
// tick register and the rsp register; ticks that walk more entries (zero or short
// delays) carry on from the saved engine state until a delay, a wait or the end stops them.
// synchronous reset clears the engine to idle with both lines released.
// a stalled rsp holds its word; one more tick can be taken while it waits.
`timescale 1ns / 1ps

module i2c_master_byte_engine #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  i2cme_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output i2cme_pkg::rsp_payload_type rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int STEPS_PER_CYCLE = 5;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   typedef struct packed {
      logic [4:0]             phase;
      logic [3:0]             bit_count;
      logic [7:0]             shift_byte;
      logic [COUNT_WIDTH-1:0] delay_count;
      logic [COUNT_WIDTH-1:0] wait_count;
      logic                   scl_drive;
      logic                   sda_drive;
      logic                   ack_choice;
      logic                   nack_seen;
      logic [1:0]             status_hold;
      logic [7:0]             rx_hold;
      logic                   done;
      logic                   stop;
   } eng_type;

   localparam eng_type ENG_RESET = '{
      phase:       i2cme_pkg::PH_IDLE,
      bit_count:   4'd0,
      shift_byte:  8'd0,
      delay_count: '0,
      wait_count:  '0,
      scl_drive:   1'b1,
      sda_drive:   1'b1,
      ack_choice:  1'b0,
      nack_seen:   1'b0,
      status_hold: i2cme_pkg::STATUS_OK,
      rx_hold:     8'd0,
      done:        1'b0,
      stop:        1'b0
   };

   logic                       enabled_ff;
   logic [15:0]                half_period_ff;
   logic [15:0]                timeout_ff;
   i2cme_pkg::req_payload_type cur_ff;
   logic                       cur_valid_ff;
   logic                       cur_first_ff;
   eng_type                    eng_ff;
   eng_type                    eng_in;
   i2cme_pkg::rsp_payload_type rsp_ff;
   logic                       rsp_valid_ff;
   logic [COUNT_WIDTH-1:0]     half_cnt;
   logic [COUNT_WIDTH-1:0]     limit_cnt;
   logic                       out_free;
   logic                       tick_finish;
   logic                       req_take;
   logic                       csr_write;

   function automatic eng_type eng_finish(eng_type s_in, logic [1:0] st);
      eng_type s;
      s = s_in;
      s.status_hold = st;
      s.done        = 1'b1;
      s.phase       = i2cme_pkg::PH_IDLE;
      s.delay_count = '0;
      s.wait_count  = '0;
      return s;
   endfunction

   function automatic eng_type eng_advance(eng_type s_in, logic last);
      eng_type s;
      s = s_in;
      if (last) begin
         s = eng_finish(s, s.nack_seen ? i2cme_pkg::STATUS_NACK : i2cme_pkg::STATUS_OK);
      end else begin
         s.phase = s.phase + 5'd1;
      end
      return s;
   endfunction

   // one entry of the bus sequence
   function automatic eng_type walk_step(eng_type s_in, logic [COUNT_WIDTH-1:0] half,
                                         logic [COUNT_WIDTH-1:0] lim, logic scl, logic sda);
      eng_type                  s;
      i2cme_pkg::seq_entry_type e;
      logic                     go_on;
      s     = s_in;
      e     = i2cme_pkg::SEQ_TABLE[0];
      go_on = 1'b0;
      if (s.stop || s.phase == i2cme_pkg::PH_IDLE
          || s.phase >= 5'(i2cme_pkg::NUM_PHASES)) begin
         s.stop = 1'b1;
      end else begin
         e = i2cme_pkg::SEQ_TABLE[s.phase];
         if (s.delay_count != '0) begin
            s.delay_count = s.delay_count - CNT_ONE;
            if (s.delay_count != '0) begin
               s.stop = 1'b1;
            end else begin
               s = eng_advance(s, e.last);
            end
         end else begin
            go_on = 1'b1;
            case (e.act)
               i2cme_pkg::ACT_SDA_HI: s.sda_drive = 1'b1;
               i2cme_pkg::ACT_SDA_LO: s.sda_drive = 1'b0;
               i2cme_pkg::ACT_SCL_HI: s.scl_drive = 1'b1;
               i2cme_pkg::ACT_SCL_LO: s.scl_drive = 1'b0;
               i2cme_pkg::ACT_SDA_BIT: begin
                  s.sda_drive  = s.shift_byte[7];
                  s.shift_byte = {s.shift_byte[6:0], 1'b0};
               end
               i2cme_pkg::ACT_ACK_SAMPLE: begin
                  s.nack_seen = sda;
                  s.scl_drive = 1'b0;
               end
               i2cme_pkg::ACT_BIT_SAMPLE: begin
                  s.shift_byte = {s.shift_byte[6:0], sda};
                  s.scl_drive  = 1'b0;
               end
               i2cme_pkg::ACT_SDA_ACK: begin
                  s.rx_hold   = s.shift_byte;
                  s.sda_drive = ~s.ack_choice;
               end
               i2cme_pkg::ACT_WAIT: begin
                  if (lim == '0) begin
                     s     = eng_finish(s, i2cme_pkg::STATUS_TIMEOUT);
                     go_on = 1'b0;
                  end else if (scl) begin
                     s.wait_count = '0;
                  end else begin
                     s.wait_count = s.wait_count + CNT_ONE;
                     go_on        = 1'b0;
                     if (s.wait_count >= lim || s.wait_count == '0) begin
                        s = eng_finish(s, i2cme_pkg::STATUS_TIMEOUT);
                     end else begin
                        s.stop = 1'b1;
                     end
                  end
               end
               i2cme_pkg::ACT_LOOP: begin
                  s.bit_count = s.bit_count + 4'd1;
                  if (s.bit_count < 4'd8) begin
                     s.phase = e.jump;
                     go_on   = 1'b0;
                  end
               end
               default: ;
            endcase
            if (go_on) begin
               if (e.dly && half != '0) begin
                  s.delay_count = half;
                  s.stop        = 1'b1;
               end else begin
                  s = eng_advance(s, e.last);
               end
            end
         end
         if (s.phase == i2cme_pkg::PH_IDLE) begin
            s.stop = 1'b1;
         end
      end
      return s;
   endfunction

   assign half_cnt  = COUNT_WIDTH'(half_period_ff);
   assign limit_cnt = COUNT_WIDTH'(timeout_ff);

   // tick prologue until the engine state is first saved, then the unrolled sequence walk
   always_comb begin
      eng_in      = eng_ff;
      eng_in.stop = 1'b0;
      if (cur_first_ff) begin
         eng_in.done = 1'b0;
         if (eng_ff.phase == i2cme_pkg::PH_IDLE
             && cur_ff.mode inside {[i2cme_pkg::MODE_START:i2cme_pkg::MODE_READ]}) begin
            if (!enabled_ff) begin
               eng_in.status_hold = i2cme_pkg::STATUS_REFUSED;
               eng_in.done        = 1'b1;
            end else begin
               eng_in.bit_count   = 4'd0;
               eng_in.delay_count = '0;
               eng_in.wait_count  = '0;
               eng_in.nack_seen   = 1'b0;
               eng_in.shift_byte  = (cur_ff.mode == i2cme_pkg::MODE_WRITE) ?
                                    cur_ff.tx_byte : 8'd0;
               eng_in.ack_choice  = cur_ff.send_ack;
               case (cur_ff.mode)
                  i2cme_pkg::MODE_START: eng_in.phase = i2cme_pkg::PH_START;
                  i2cme_pkg::MODE_STOP:  eng_in.phase = i2cme_pkg::PH_STOP;
                  i2cme_pkg::MODE_WRITE: eng_in.phase = i2cme_pkg::PH_WRITE;
                  default:               eng_in.phase = i2cme_pkg::PH_READ;
               endcase
            end
         end
      end
      for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
         eng_in = walk_step(eng_in, half_cnt, limit_cnt, cur_ff.scl_in, cur_ff.sda_in);
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign tick_finish = cur_valid_ff && eng_in.stop && out_free;
   assign req_ready   = !cur_valid_ff || tick_finish;
   assign req_take    = req_valid && req_ready;
   assign csr_write   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_first_ff <= 1'b0;
         eng_ff       <= ENG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cur_valid_ff && (!eng_in.stop || out_free)) begin
            eng_ff <= eng_in;
         end
         if (req_take) begin
            cur_ff       <= req_data;
            cur_valid_ff <= 1'b1;
            cur_first_ff <= 1'b1;
         end else begin
            if (tick_finish) begin
               cur_valid_ff <= 1'b0;
            end
            if (cur_valid_ff && (!eng_in.stop || out_free)) begin
               cur_first_ff <= 1'b0;
            end
         end
         if (tick_finish) begin
            rsp_valid_ff       <= 1'b1;
            rsp_ff.scl_release <= eng_in.scl_drive;
            rsp_ff.sda_release <= eng_in.sda_drive;
            rsp_ff.busy_res    <= (eng_in.phase != i2cme_pkg::PH_IDLE);
            rsp_ff.done_res    <= eng_in.done;
            rsp_ff.status      <= eng_in.status_hold;
            rsp_ff.rx_byte     <= eng_in.rx_hold;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         half_period_ff <= i2cme_pkg::HALF_PERIOD_RESET;
         timeout_ff     <= i2cme_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            i2cme_pkg::REG_ENABLED:     enabled_ff     <= pwdata[0];
            i2cme_pkg::REG_HALF_PERIOD: half_period_ff <= pwdata[15:0];
            i2cme_pkg::REG_TIMEOUT:     timeout_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         i2cme_pkg::REG_ENABLED:     prdata = {31'd0, enabled_ff};
         i2cme_pkg::REG_HALF_PERIOD: prdata = {16'd0, half_period_ff};
         i2cme_pkg::REG_TIMEOUT:     prdata = {16'd0, timeout_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/i2cme_checker.sv]
// i2cme_checker: port-level checks on the rsp channel of the i2c master byte
// engine, bound to i2c_master_byte_engine. Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input i2cme_pkg::rsp_payload_type rsp_data
);

   // no rsp straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a finished or refused command leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done with busy still set");

   // a refused command cannot happen while a sequence runs
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.busy_res ##1 rsp_valid && rsp_data.done_res
      |-> rsp_data.status != i2cme_pkg::STATUS_REFUSED)
      else $error("refusal while busy");

   // stalled transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

endmodule

bind i2c_master_byte_engine i2cme_checker u_i2cme_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/i2c_master_byte_engine_tb.sv]
// i2c_master_byte_engine_tb: self-checking bench for the i2c master byte engine. It drives
// bus ticks with a simple slave model, predicts every status word and checks it field by field.
// Depends on i2cme_pkg and i2c_master_byte_engine.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int TICKS_PER_SETTING = 230;

   localparam bit [4:0] IDLE_ENTRY = 5'd0;
   localparam bit [4:0] START_ENTRY = 5'd1;
   localparam bit [4:0] STOP_ENTRY = 5'd6;
   localparam bit [4:0] WRITE_ENTRY = 5'd10;
   localparam bit [4:0] READ_ENTRY = 5'd19;
   localparam bit [4:0] ENTRY_COUNT = 5'd30;

   typedef struct packed {
      i2cme_pkg::act_type act;
      bit                 dly;
      bit                 last;
      bit [4:0]           jump;
   } bus_step_type;

   class bus_sequence_scoreboard;
      bit        cfg_enabled = 1'b0;
      bit [15:0] cfg_half_period = i2cme_pkg::HALF_PERIOD_RESET;
      bit [15:0] cfg_timeout = i2cme_pkg::TIMEOUT_RESET;
      bit [4:0]  seq_phase = IDLE_ENTRY;
      bit [3:0]  bit_count = 4'd0;
      bit [7:0]  shift_byte = 8'd0;
      bit [15:0] delay_left = 16'd0;
      bit [15:0] low_samples = 16'd0;
      bit        scl_drive = 1'b1;
      bit        sda_drive = 1'b1;
      bit        ack_choice = 1'b0;
      bit        nack_seen = 1'b0;
      bit [1:0]  status_hold = i2cme_pkg::STATUS_OK;
      bit [7:0]  rx_hold = 8'd0;
      bit        done_now;
      int        mismatch_count = 0;
      i2cme_pkg::rsp_payload_type expected_words[$];

      function void write_register(logic [1:0] index, logic [31:0] value);
         case (index)
            i2cme_pkg::REG_ENABLED: cfg_enabled = value[0];
            i2cme_pkg::REG_HALF_PERIOD: cfg_half_period = value[15:0];
            i2cme_pkg::REG_TIMEOUT: cfg_timeout = value[15:0];
            default: ;
         endcase
      endfunction

      function bus_step_type step_entry(bit [4:0] ph);
         case (ph)
            5'd1: return '{i2cme_pkg::ACT_SDA_HI, 1'b1, 1'b0, 5'd0};
            5'd2: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd3: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd4: return '{i2cme_pkg::ACT_SDA_LO, 1'b1, 1'b0, 5'd0};
            5'd5: return '{i2cme_pkg::ACT_SCL_LO, 1'b1, 1'b1, 5'd0};
            5'd6: return '{i2cme_pkg::ACT_SDA_LO, 1'b1, 1'b0, 5'd0};
            5'd7: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd8: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd9: return '{i2cme_pkg::ACT_SDA_HI, 1'b1, 1'b1, 5'd0};
            5'd10: return '{i2cme_pkg::ACT_SDA_BIT, 1'b1, 1'b0, 5'd0};
            5'd11: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd12: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd13: return '{i2cme_pkg::ACT_SCL_LO, 1'b1, 1'b0, 5'd0};
            5'd14: return '{i2cme_pkg::ACT_LOOP, 1'b0, 1'b0, WRITE_ENTRY};
            5'd15: return '{i2cme_pkg::ACT_SDA_HI, 1'b1, 1'b0, 5'd0};
            5'd16: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd17: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd18: return '{i2cme_pkg::ACT_ACK_SAMPLE, 1'b1, 1'b1, 5'd0};
            5'd19: return '{i2cme_pkg::ACT_SDA_HI, 1'b0, 1'b0, 5'd0};
            5'd20: return '{i2cme_pkg::ACT_NOP, 1'b1, 1'b0, 5'd0};
            5'd21: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd22: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd23: return '{i2cme_pkg::ACT_BIT_SAMPLE, 1'b0, 1'b0, 5'd0};
            5'd24: return '{i2cme_pkg::ACT_LOOP, 1'b0, 1'b0, READ_ENTRY + 5'd1};
            5'd25: return '{i2cme_pkg::ACT_SDA_ACK, 1'b1, 1'b0, 5'd0};
            5'd26: return '{i2cme_pkg::ACT_SCL_HI, 1'b1, 1'b0, 5'd0};
            5'd27: return '{i2cme_pkg::ACT_WAIT, 1'b0, 1'b0, 5'd0};
            5'd28: return '{i2cme_pkg::ACT_SCL_LO, 1'b1, 1'b0, 5'd0};
            5'd29: return '{i2cme_pkg::ACT_SDA_HI, 1'b0, 1'b1, 5'd0};
            default: return '{i2cme_pkg::ACT_NOP, 1'b0, 1'b1, 5'd0};
         endcase
      endfunction

      function void end_command(bit [1:0] st);
         status_hold = st;
         done_now = 1'b1;
         seq_phase = IDLE_ENTRY;
         delay_left = 16'd0;
         low_samples = 16'd0;
      endfunction

      function void next_step(bus_step_type e);
         if (e.last)
            end_command(nack_seen ? i2cme_pkg::STATUS_NACK : i2cme_pkg::STATUS_OK);
         else
            seq_phase = seq_phase + 5'd1;
      endfunction

      // walks entries until a delay, a low scl wait or the end of the command
      function void walk_sequence(bit scl_in, bit sda_in);
         bus_step_type e;
         while (seq_phase != IDLE_ENTRY && seq_phase < ENTRY_COUNT) begin
            e = step_entry(seq_phase);
            if (delay_left != 16'd0) begin
               delay_left = delay_left - 16'd1;
               if (delay_left != 16'd0)
                  return;
               next_step(e);
               continue;
            end
            case (e.act)
               i2cme_pkg::ACT_SDA_HI: sda_drive = 1'b1;
               i2cme_pkg::ACT_SDA_LO: sda_drive = 1'b0;
               i2cme_pkg::ACT_SCL_HI: scl_drive = 1'b1;
               i2cme_pkg::ACT_SCL_LO: scl_drive = 1'b0;
               i2cme_pkg::ACT_SDA_BIT: begin
                  sda_drive = shift_byte[7];
                  shift_byte = {shift_byte[6:0], 1'b0};
               end
               i2cme_pkg::ACT_ACK_SAMPLE: begin
                  nack_seen = sda_in;
                  scl_drive = 1'b0;
               end
               i2cme_pkg::ACT_BIT_SAMPLE: begin
                  shift_byte = {shift_byte[6:0], sda_in};
                  scl_drive = 1'b0;
               end
               i2cme_pkg::ACT_SDA_ACK: begin
                  rx_hold = shift_byte;
                  sda_drive = !ack_choice;
               end
               i2cme_pkg::ACT_WAIT: begin
                  if (cfg_timeout == 16'd0) begin
                     end_command(i2cme_pkg::STATUS_TIMEOUT);
                     return;
                  end
                  if (scl_in)
                     low_samples = 16'd0;
                  else begin
                     low_samples = low_samples + 16'd1;
                     if (low_samples >= cfg_timeout || low_samples == 16'd0)
                        end_command(i2cme_pkg::STATUS_TIMEOUT);
                     return;
                  end
               end
               i2cme_pkg::ACT_LOOP: begin
                  bit_count = bit_count + 4'd1;
                  if (bit_count < 4'd8) begin
                     seq_phase = e.jump;
                     continue;
                  end
               end
               default: ;
            endcase
            if (e.dly && cfg_half_period != 16'd0) begin
               delay_left = cfg_half_period;
               return;
            end
            next_step(e);
         end
      endfunction

      function void note_tick(i2cme_pkg::req_payload_type item);
         i2cme_pkg::rsp_payload_type want;
         done_now = 1'b0;
         if (seq_phase == IDLE_ENTRY) begin
            if (item.mode >= i2cme_pkg::MODE_START && item.mode <= i2cme_pkg::MODE_READ) begin
               if (!cfg_enabled) begin
                  status_hold = i2cme_pkg::STATUS_REFUSED;
                  done_now = 1'b1;
               end else begin
                  bit_count = 4'd0;
                  delay_left = 16'd0;
                  low_samples = 16'd0;
                  nack_seen = 1'b0;
                  shift_byte = (item.mode == i2cme_pkg::MODE_WRITE) ? item.tx_byte : 8'd0;
                  ack_choice = item.send_ack;
                  case (item.mode)
                     i2cme_pkg::MODE_START: seq_phase = START_ENTRY;
                     i2cme_pkg::MODE_STOP: seq_phase = STOP_ENTRY;
                     i2cme_pkg::MODE_WRITE: seq_phase = WRITE_ENTRY;
                     default: seq_phase = READ_ENTRY;
                  endcase
                  walk_sequence(item.scl_in, item.sda_in);
               end
            end
         end else
            walk_sequence(item.scl_in, item.sda_in);
         want.scl_release = scl_drive;
         want.sda_release = sda_drive;
         want.busy_res = (seq_phase != IDLE_ENTRY);
         want.done_res = done_now;
         want.status = status_hold;
         want.rx_byte = rx_hold;
         expected_words.push_back(want);
      endfunction

      function void check_status_word(i2cme_pkg::rsp_payload_type got);
         i2cme_pkg::rsp_payload_type want;
         if (expected_words.size() == 0) begin
            $error("rsp transfer with no status word expected");
            mismatch_count++;
            return;
         end
         want = expected_words.pop_front();
         if (got.scl_release !== want.scl_release) begin
            $error("scl_release: expected %0d actual %0d", want.scl_release, got.scl_release);
            mismatch_count++;
         end
         if (got.sda_release !== want.sda_release) begin
            $error("sda_release: expected %0d actual %0d", want.sda_release, got.sda_release);
            mismatch_count++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d actual %0d", want.busy_res, got.busy_res);
            mismatch_count++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d actual %0d", want.done_res, got.done_res);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.rx_byte !== want.rx_byte) begin
            $error("rx_byte: expected %0h actual %0h", want.rx_byte, got.rx_byte);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   i2cme_pkg::req_payload_type req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   i2cme_pkg::rsp_payload_type rsp_data;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [3:0]                 paddr = 4'd0;
   logic [31:0]                pwdata = 32'd0;
   logic [31:0]                prdata;
   logic                       pready;

   bus_sequence_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit bus_open = 1'b0;
   int stretch_left = 0;
   int cycle_count = 0;

   i2c_master_byte_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   task send_tick(i2cme_pkg::req_payload_type item);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(item);
   endtask

   task send_cmd(logic [2:0] m, logic [7:0] tx, logic ack, logic scl, logic sda);
      i2cme_pkg::req_payload_type item;
      item.mode = m;
      item.tx_byte = tx;
      item.send_ack = ack;
      item.scl_in = scl;
      item.sda_in = sda;
      send_tick(item);
   endtask

   task drain_transfers();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_register(logic [1:0] index, logic [31:0] value);
      logic [31:0] mask;
      mask = (index == i2cme_pkg::REG_ENABLED) ? 32'h1 : 32'hffff;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(index, value);
      // read back
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (((prdata ^ value) & mask) != 32'd0) begin
         $error("prdata: expected %0h actual %0h", value & mask, prdata & mask);
         sb.mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task set_config(logic en, logic [15:0] half_period, logic [15:0] limit);
      write_register(i2cme_pkg::REG_ENABLED, {31'd0, en});
      write_register(i2cme_pkg::REG_HALF_PERIOD, {16'd0, half_period});
      write_register(i2cme_pkg::REG_TIMEOUT, {16'd0, limit});
   endtask

   // mostly well-formed transactions: start, data bytes, stop
   function logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 3'($urandom_range(i2cme_pkg::MODE_START, i2cme_pkg::MODE_READ));
      if (!bus_open)
         return i2cme_pkg::MODE_START;
      r = $urandom_range(0, 9);
      if (r < 4)
         return i2cme_pkg::MODE_WRITE;
      if (r < 8)
         return i2cme_pkg::MODE_READ;
      if (r == 8)
         return i2cme_pkg::MODE_START;
      return i2cme_pkg::MODE_STOP;
   endfunction

   // slave side: scl stretched now and then, sda biased toward ack
   function i2cme_pkg::req_payload_type build_bus_tick();
      i2cme_pkg::req_payload_type item;
      item.tx_byte = 8'($urandom_range(0, 255));
      item.send_ack = 1'($urandom_range(0, 1));
      if (sb.seq_phase == IDLE_ENTRY && $urandom_range(0, 3) != 0) begin
         item.mode = pick_command();
         if (item.mode == i2cme_pkg::MODE_START)
            bus_open = 1'b1;
         else if (item.mode == i2cme_pkg::MODE_STOP)
            bus_open = 1'b0;
      end else if (sb.seq_phase == IDLE_ENTRY && $urandom_range(0, 1) == 0)
         item.mode = 3'($urandom_range(i2cme_pkg::MODE_READ + 1, 7));
      else
         item.mode = 3'($urandom_range(0, 7));
      if (stretch_left == 0 && $urandom_range(0, 11) == 0)
         stretch_left = $urandom_range(1, 8);
      if (stretch_left > 0) begin
         item.scl_in = 1'b0;
         stretch_left--;
      end else
         item.scl_in = 1'b1;
      if ($urandom_range(0, 29) == 0)
         item.scl_in = ~item.scl_in;
      item.sda_in = ($urandom_range(0, 2) == 0);
      return item;
   endfunction

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("i2c_master_byte_engine regression: fail");
      $finish;
   end

   initial begin
      int stall;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_status_word(rsp_data);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // refused while disabled
      send_cmd(i2cme_pkg::MODE_START, 8'h00, 1'b0, 1'b1, 1'b1);
      send_cmd(i2cme_pkg::MODE_TICK, 8'hff, 1'b1, 1'b1, 1'b0);
      drain_transfers();
      set_config(1'b1, 16'd0, 16'd2);
      send_cmd(i2cme_pkg::MODE_START, 8'h00, 1'b0, 1'b1, 1'b1);
      send_cmd(i2cme_pkg::MODE_WRITE, 8'hff, 1'b0, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_WRITE, 8'h00, 1'b0, 1'b1, 1'b1);
      send_cmd(i2cme_pkg::MODE_WRITE, 8'h80, 1'b1, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_WRITE, 8'h01, 1'b0, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_READ, 8'h00, 1'b1, 1'b1, 1'b1);
      send_cmd(i2cme_pkg::MODE_READ, 8'hff, 1'b0, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_TICK, 8'h55, 1'b1, 1'b0, 1'b1);
      for (int m = i2cme_pkg::MODE_READ + 1; m < 8; m++)
         send_cmd(3'(m), 8'haa, 1'b0, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
      // scl held low until timeout
      send_cmd(i2cme_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b1);
      send_cmd(i2cme_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
      send_cmd(i2cme_pkg::MODE_WRITE, 8'ha5, 1'b0, 1'b1, 1'b0);
      send_cmd(i2cme_pkg::MODE_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
      drain_transfers();

      // long delay, shortened for the rest of the command
      set_config(1'b1, 16'd300, 16'hffff);
      send_cmd(i2cme_pkg::MODE_START, 8'h00, 1'b0, 1'b1, 1'b1);
      drain_transfers();
      write_register(i2cme_pkg::REG_HALF_PERIOD, 32'd1);
      no_idle = 1'b1;
      while (sb.seq_phase != IDLE_ENTRY)
         send_cmd(i2cme_pkg::MODE_TICK, 8'h00, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
      drain_transfers();
      no_idle = 1'b0;

      for (int setting = 0; setting < 6; setting++) begin
         case (setting)
            0: set_config(1'b1, 16'd1, 16'd6);
            1: set_config(1'b1, 16'd0, 16'd3);
            2: set_config(1'b1, 16'd2, 16'hffff);
            3: set_config(1'b0, 16'd3, 16'd1);
            4: set_config(1'b1, 16'd0, 16'd0);
            default: set_config(1'b1, 16'd3, 16'd4);
         endcase
         no_idle = (setting == 2);
         for (int n = 0; n < TICKS_PER_SETTING; n++)
            send_tick(build_bus_tick());
         drain_transfers();
      end

      if (sb.mismatch_count == 0 && sb.expected_words.size() == 0)
         $display("i2c_master_byte_engine regression: pass");
      else
         $display("i2c_master_byte_engine regression: fail");
      $finish;
   end

endmodule

[files.f]
rtl/core/i2cme_pkg.sv
rtl/core/i2c_master_byte_engine.sv
rtl/core/i2cme_checker.sv
verif/i2c_master_byte_engine_tb.sv
